>>> design/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, constants and address helpers of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int NUM_RANKS = 11;
	localparam int MAX_PAGES = 1024;
	localparam int PW        = $clog2(MAX_PAGES);
	localparam int CW        = PW + 1;
	localparam int RW        = 4;
	localparam int BAW       = PW + 1;
	localparam int NBIT      = 2 * MAX_PAGES;
	localparam int CTRW      = BAW + 1;

	typedef enum logic [2:0] {
		MODE_INIT  = 3'd0,
		MODE_ALLOC = 3'd1,
		MODE_FREE  = 3'd2,
		MODE_QRANK = 3'd3,
		MODE_QCNT  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVAL   = 2'd1,
		ST_NOSPACE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CLR, S_FILL, S_ASRCH, S_ARD, S_ACHK, S_ASPLIT,
		S_FCHK, S_FM, S_FMCHK, S_QCHK, S_QB, S_QBCHK, S_DONE
	} seq_state_t;

	typedef struct packed {
		logic [2:0]    mode;
		logic [RW-1:0] rank;
		logic [PW-1:0] page_index;
		logic [CW-1:0] page_count;
	} req_t;

	typedef struct packed {
		logic [1:0]    status;
		logic [PW-1:0] block_page;
		logic [CW-1:0] answer;
	} res_t;

	// free bit of block i at rank r lives at (NBIT - NBIT>>(r-1)) + i
	function automatic logic [BAW-1:0] bit_addr(logic [RW-1:0] r, logic [PW-1:0] i);
		logic [BAW:0] base;
		base = (BAW+1)'(NBIT) - ((BAW+1)'(NBIT) >> (r - RW'(1)));
		return base[BAW-1:0] + BAW'(i);
	endfunction

endpackage

>>> design/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
	parameter int AW = 10,
	parameter int DW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

>>> design/bpa_seq.sv
// ----------------------------------------------------------------------------
// bpa_seq
// Sequencer over the free-bit and held-rank memories and the free counters.
// ----------------------------------------------------------------------------
module bpa_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bpa_pkg::req_t       req,
	input  logic                res_free,
	output logic                ready,
	output logic                res_valid,
	output bpa_pkg::res_t       res
);
	localparam int PW = bpa_pkg::PW;
	localparam int CW = bpa_pkg::CW;
	localparam int RW = bpa_pkg::RW;
	localparam int BAW = bpa_pkg::BAW;
	localparam int CTRW = bpa_pkg::CTRW;
	localparam int MR = bpa_pkg::NUM_RANKS;

	bpa_pkg::seq_state_t state_q, state_d;
	logic [RW-1:0]   r_q, r_d, want_q, want_d, top_q, top_d;
	logic [CTRW-1:0] ctr_q, ctr_d;
	logic [PW-1:0]   blk_q, blk_d, page_q, page_d, bp_q, bp_d;
	logic [CW-1:0]   cur_q, cur_d, left_q, left_d, total_q, total_d, ans_q, ans_d;
	logic [1:0]      st_q, st_d;
	logic [CW-1:0]   cnt_q [MR];
	logic            cnt_clr, cnt_inc, cnt_dec;
	logic [RW-1:0]   cnt_r;

	logic            b_we, b_wd, b_rd;
	logic [BAW-1:0]  b_wa, b_ra;
	logic            h_we;
	logic [RW-1:0]   h_wd, h_rd;
	logic [PW-1:0]   h_wa, h_ra;

	logic [CW-1:0]   blocks_r;
	logic [RW-1:0]   top_pc, pick;
	logic [CW-1:0]   pick_bp;
	logic [PW-1:0]   bud, qblk, blk_held;
	logic [CW-1:0]   split_page;

	bpa_ram #(.AW(BAW), .DW(1)) u_bits (
		.clk(clk), .we(b_we), .wr_addr(b_wa), .wr_data(b_wd),
		.rd_addr(b_ra), .rd_data(b_rd)
	);

	bpa_ram #(.AW(PW), .DW(RW)) u_held (
		.clk(clk), .we(h_we), .wr_addr(h_wa), .wr_data(h_wd),
		.rd_addr(h_ra), .rd_data(h_rd)
	);

	assign blocks_r   = total_q >> (r_q - RW'(1));
	assign bud        = blk_q ^ PW'(1);
	assign qblk       = page_q >> (r_q - RW'(1));
	assign blk_held   = page_q >> (h_rd - RW'(1));
	assign split_page = CW'(blk_q) << (r_q - RW'(1));

	always_comb begin
		top_pc = RW'(1);
		for (int q = 2; q <= MR; q++) begin
			if ((CW+1)'(1 << (q - 1)) <= (CW+1)'(req.page_count)) begin
				top_pc = RW'(q);
			end
		end
		pick    = RW'(1);
		pick_bp = CW'(1);
		for (int q = 2; q <= MR; q++) begin
			if (RW'(q) <= top_q && CW'(1 << (q - 1)) <= left_q
					&& (cur_q & CW'((1 << (q - 1)) - 1)) == '0) begin
				pick    = RW'(q);
				pick_bp = CW'(1 << (q - 1));
			end
		end
	end

	always_comb begin
		state_d = state_q;
		r_d = r_q; want_d = want_q; top_d = top_q; ctr_d = ctr_q;
		blk_d = blk_q; page_d = page_q; bp_d = bp_q;
		cur_d = cur_q; left_d = left_q; total_d = total_q; ans_d = ans_q; st_d = st_q;
		cnt_clr = 1'b0; cnt_inc = 1'b0; cnt_dec = 1'b0; cnt_r = r_q;
		b_we = 1'b0; b_wd = 1'b0; b_wa = '0; b_ra = '0;
		h_we = 1'b0; h_wd = '0; h_wa = page_q; h_ra = page_q;
		unique case (state_q)
			bpa_pkg::S_IDLE: begin
				h_ra = req.page_index;
				if (start) begin
					st_d = bpa_pkg::ST_INVAL; bp_d = '0; ans_d = '0;
					page_d = req.page_index; want_d = req.rank; r_d = req.rank;
					state_d = bpa_pkg::S_DONE;
					case (req.mode)
						bpa_pkg::MODE_INIT: begin
							if (req.page_count != '0
									&& req.page_count <= CW'(bpa_pkg::MAX_PAGES)) begin
								cnt_clr = 1'b1;
								top_d = top_pc; total_d = req.page_count;
								ctr_d = '0; state_d = bpa_pkg::S_CLR;
							end
						end
						bpa_pkg::MODE_ALLOC: begin
							if (req.rank != '0 && req.rank <= top_q) begin
								state_d = bpa_pkg::S_ASRCH;
							end
						end
						bpa_pkg::MODE_FREE: begin
							if (CW'(req.page_index) < total_q) begin
								state_d = bpa_pkg::S_FCHK;
							end
						end
						bpa_pkg::MODE_QRANK: begin
							if (CW'(req.page_index) < total_q) begin
								state_d = bpa_pkg::S_QCHK;
							end
						end
						bpa_pkg::MODE_QCNT: begin
							if (req.rank != '0 && req.rank <= top_q) begin
								st_d = bpa_pkg::ST_OK;
								ans_d = cnt_q[req.rank - RW'(1)];
							end
						end
						default: ;
					endcase
				end
			end
			bpa_pkg::S_CLR: begin
				b_we = 1'b1; b_wa = ctr_q[BAW-1:0]; b_wd = 1'b0;
				h_we = (ctr_q < CTRW'(bpa_pkg::MAX_PAGES));
				h_wa = ctr_q[PW-1:0]; h_wd = '0;
				ctr_d = ctr_q + CTRW'(1);
				if (ctr_q == CTRW'(bpa_pkg::NBIT - 1)) begin
					cur_d = '0; left_d = total_q; state_d = bpa_pkg::S_FILL;
				end
			end
			bpa_pkg::S_FILL: begin
				if (left_q == '0) begin
					st_d = bpa_pkg::ST_OK; state_d = bpa_pkg::S_DONE;
				end else begin
					b_we = 1'b1; b_wd = 1'b1;
					b_wa = bpa_pkg::bit_addr(pick, PW'(cur_q >> (pick - RW'(1))));
					cnt_inc = 1'b1; cnt_r = pick;
					cur_d = cur_q + pick_bp; left_d = left_q - pick_bp;
				end
			end
			bpa_pkg::S_ASRCH: begin
				if (r_q > top_q) begin
					st_d = bpa_pkg::ST_NOSPACE; state_d = bpa_pkg::S_DONE;
				end else if (cnt_q[r_q - RW'(1)] == '0) begin
					r_d = r_q + RW'(1);
				end else begin
					ctr_d = '0; state_d = bpa_pkg::S_ARD;
				end
			end
			bpa_pkg::S_ARD: begin
				b_ra = bpa_pkg::bit_addr(r_q, ctr_q[PW-1:0]);
				if (ctr_q >= CTRW'(blocks_r) || ctr_q >= CTRW'(bpa_pkg::MAX_PAGES)) begin
					st_d = bpa_pkg::ST_NOSPACE; state_d = bpa_pkg::S_DONE;
				end else begin
					state_d = bpa_pkg::S_ACHK;
				end
			end
			bpa_pkg::S_ACHK: begin
				if (b_rd) begin
					b_we = 1'b1; b_wd = 1'b0;
					b_wa = bpa_pkg::bit_addr(r_q, ctr_q[PW-1:0]);
					cnt_dec = 1'b1;
					blk_d = ctr_q[PW-1:0];
					state_d = bpa_pkg::S_ASPLIT;
				end else begin
					ctr_d = ctr_q + CTRW'(1); state_d = bpa_pkg::S_ARD;
				end
			end
			bpa_pkg::S_ASPLIT: begin
				if (r_q > want_q) begin
					r_d = r_q - RW'(1);
					b_we = 1'b1; b_wd = 1'b1;
					b_wa = bpa_pkg::bit_addr(r_q - RW'(1), {blk_q[PW-2:0], 1'b1});
					cnt_inc = 1'b1; cnt_r = r_q - RW'(1);
					blk_d = {blk_q[PW-2:0], 1'b0};
				end else begin
					state_d = bpa_pkg::S_DONE;
					if (split_page >= total_q) begin
						st_d = bpa_pkg::ST_NOSPACE;
					end else begin
						h_we = 1'b1; h_wa = split_page[PW-1:0]; h_wd = r_q;
						st_d = bpa_pkg::ST_OK; bp_d = split_page[PW-1:0];
					end
				end
			end
			bpa_pkg::S_FCHK: begin
				if (h_rd == '0 || h_rd > top_q) begin
					state_d = bpa_pkg::S_DONE;
				end else begin
					h_we = 1'b1; h_wd = '0;
					r_d = h_rd; blk_d = blk_held;
					state_d = bpa_pkg::S_FM;
				end
			end
			bpa_pkg::S_FM: begin
				b_ra = bpa_pkg::bit_addr(r_q, bud);
				if (r_q < top_q && CW'(bud) < blocks_r) begin
					state_d = bpa_pkg::S_FMCHK;
				end else begin
					b_we = 1'b1; b_wd = 1'b1; b_wa = bpa_pkg::bit_addr(r_q, blk_q);
					cnt_inc = 1'b1;
					st_d = bpa_pkg::ST_OK; state_d = bpa_pkg::S_DONE;
				end
			end
			bpa_pkg::S_FMCHK: begin
				if (b_rd) begin
					b_we = 1'b1; b_wd = 1'b0; b_wa = bpa_pkg::bit_addr(r_q, bud);
					cnt_dec = (cnt_q[r_q - RW'(1)] != '0);
					blk_d = blk_q >> 1; r_d = r_q + RW'(1);
					state_d = bpa_pkg::S_FM;
				end else begin
					b_we = 1'b1; b_wd = 1'b1; b_wa = bpa_pkg::bit_addr(r_q, blk_q);
					cnt_inc = 1'b1;
					st_d = bpa_pkg::ST_OK; state_d = bpa_pkg::S_DONE;
				end
			end
			bpa_pkg::S_QCHK: begin
				if (h_rd != '0 && h_rd <= top_q) begin
					st_d = bpa_pkg::ST_OK; ans_d = CW'(h_rd);
					state_d = bpa_pkg::S_DONE;
				end else begin
					r_d = top_q; state_d = bpa_pkg::S_QB;
				end
			end
			bpa_pkg::S_QB: begin
				b_ra = bpa_pkg::bit_addr(r_q, qblk);
				if (r_q == '0) begin
					state_d = bpa_pkg::S_DONE;
				end else if (CW'(qblk) < blocks_r) begin
					state_d = bpa_pkg::S_QBCHK;
				end else begin
					r_d = r_q - RW'(1);
				end
			end
			bpa_pkg::S_QBCHK: begin
				if (b_rd) begin
					st_d = bpa_pkg::ST_OK; ans_d = CW'(r_q);
					state_d = bpa_pkg::S_DONE;
				end else begin
					r_d = r_q - RW'(1); state_d = bpa_pkg::S_QB;
				end
			end
			bpa_pkg::S_DONE: begin
				if (res_free) begin
					state_d = bpa_pkg::S_IDLE;
				end
			end
			default: state_d = bpa_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpa_pkg::S_IDLE;
			top_q   <= '0;
			total_q <= '0;
			for (int k = 0; k < MR; k++) begin
				cnt_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			total_q <= total_d;
			for (int k = 0; k < MR; k++) begin
				if (cnt_clr) begin
					cnt_q[k] <= '0;
				end else if (cnt_r == RW'(k + 1)) begin
					if (cnt_inc) begin
						cnt_q[k] <= cnt_q[k] + CW'(1);
					end else if (cnt_dec) begin
						cnt_q[k] <= cnt_q[k] - CW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		r_q <= r_d; want_q <= want_d; ctr_q <= ctr_d;
		blk_q <= blk_d; page_q <= page_d; bp_q <= bp_d;
		cur_q <= cur_d; left_q <= left_d; ans_q <= ans_d; st_q <= st_d;
	end

	assign ready          = (state_q == bpa_pkg::S_IDLE);
	assign res_valid      = (state_q == bpa_pkg::S_DONE);
	assign res.status     = st_q;
	assign res.block_page = bp_q;
	assign res.answer     = ans_q;
endmodule

>>> design/buddy_page_allocator.sv
// Work per item, accept to output: a count query answers from the counters; alloc
//   skips ranks with no free block, scans free bits and splits ranks; free merges
//   with each free buddy until a busy buddy or the top rank ends it; a rank query probes ranks.
// Init clears all 2048 free bits, then sets one per free block. Errors found at accept go straight to the result.
// Throughput: one item at a time; in_stall stays high until the result is registered.
// Reset is asynchronous: counters, top rank and page total cleared, page_count
//   register set to 1024; memories hold nothing valid until the first init.
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy page allocator with init, alloc, free and query items, one result each.
// ----------------------------------------------------------------------------
module buddy_page_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] page_count,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [3:0]  rank,
	input  logic [9:0]  page_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [9:0]  block_page,
	output logic [10:0] answer
);
	logic [bpa_pkg::CW-1:0] page_count_q;
	logic                   seq_ready, res_valid, res_free, start, out_valid_q;
	bpa_pkg::req_t          req;
	bpa_pkg::res_t          res, out_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = !seq_ready;
	assign start     = in_valid && seq_ready;
	assign res_free  = !out_valid_q || !out_stall;

	assign req.mode       = mode;
	assign req.rank       = rank;
	assign req.page_index = page_index;
	assign req.page_count = page_count_q;

	bpa_seq u_seq (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.res_free(res_free), .ready(seq_ready), .res_valid(res_valid), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= 11'd1024;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				page_count_q <= page_count;
			end
			if (res_free) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign block_page = out_q.block_page;
	assign answer     = out_q.answer;

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("accepted item not held");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3) else $error("bad status code");
	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != bpa_pkg::ST_OK |-> block_page == '0 && answer == '0)
		else $error("nonzero payload on error");
`endif
endmodule
